[src/rtnp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnp_pkg
// Shared types and constants for the raster to tile nibble packer.
// ----------------------------------------------------------------------------
package rtnp_pkg;

    localparam int MAX_TILES_WIDE = 32;
    localparam int MAX_TILES_HIGH = 32;

    localparam int PIX_W   = 4;
    localparam int PIX_N   = 8;
    localparam int WORD_W  = PIX_W * PIX_N;
    localparam int ADDR_W  = 13;
    localparam int SIZE_W  = 6;
    localparam int ROW_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam int COL_W  = (MAX_TILES_WIDE > 1) ? $clog2(MAX_TILES_WIDE) : 1;
    localparam int BAND_W = (MAX_TILES_HIGH > 1) ? $clog2(MAX_TILES_HIGH) : 1;
    localparam int EFFW_W = $clog2(MAX_TILES_WIDE + 1);
    localparam int EFFH_W = $clog2(MAX_TILES_HIGH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH_TILES  = 2'd0,
        REG_HEIGHT_TILES = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix7;
        logic [PIX_W-1:0] pix6;
        logic [PIX_W-1:0] pix5;
        logic [PIX_W-1:0] pix4;
        logic [PIX_W-1:0] pix3;
        logic [PIX_W-1:0] pix2;
        logic [PIX_W-1:0] pix1;
        logic [PIX_W-1:0] pix0;
    } pix_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic [ADDR_W-1:0] word_address;
        logic              frame_end;
    } tile_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic              frame_end;
    } rtnp_pos_t;

endpackage

[src/rtnp_addr_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnp_addr_gen
// Tile column / row / band counters and tile-order word address.
// ----------------------------------------------------------------------------
module rtnp_addr_gen (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [rtnp_pkg::SIZE_W-1:0] width_tiles,
    input  logic [rtnp_pkg::SIZE_W-1:0] height_tiles,
    output rtnp_pkg::rtnp_pos_t        pos
);
    import rtnp_pkg::*;

    logic [COL_W-1:0]  tile_column_reg, tile_column_next;
    logic [ROW_W-1:0]  row_in_tile_reg, row_in_tile_next;
    logic [BAND_W-1:0] tile_band_reg, tile_band_next;
    logic [EFFW_W-1:0] w_eff;
    logic [EFFH_W-1:0] h_eff;
    logic              col_last, row_last, band_last;
    logic [ADDR_W-1:0] band_base;

    // zero acts as one, oversize clamps
    always_comb
    begin
        if (width_tiles == '0)
            w_eff = EFFW_W'(1);
        else if (int'(width_tiles) > MAX_TILES_WIDE)
            w_eff = EFFW_W'(MAX_TILES_WIDE);
        else
            w_eff = EFFW_W'(width_tiles);

        if (height_tiles == '0)
            h_eff = EFFH_W'(1);
        else if (int'(height_tiles) > MAX_TILES_HIGH)
            h_eff = EFFH_W'(MAX_TILES_HIGH);
        else
            h_eff = EFFH_W'(height_tiles);
    end

    assign col_last  = ({1'b0, tile_column_reg} + (COL_W+1)'(1)) >= (COL_W+1)'(w_eff);
    assign row_last  = row_in_tile_reg == '1;
    assign band_last = ({1'b0, tile_band_reg} + (BAND_W+1)'(1)) >= (BAND_W+1)'(h_eff);

    assign band_base = ADDR_W'(tile_band_reg) * ADDR_W'(w_eff);

    assign pos.word_address = ((band_base + ADDR_W'(tile_column_reg)) << ROW_W)
                              + ADDR_W'(row_in_tile_reg);
    assign pos.frame_end    = col_last && row_last && band_last;

    always_comb
    begin
        tile_column_next = tile_column_reg;
        row_in_tile_next = row_in_tile_reg;
        tile_band_next   = tile_band_reg;
        if (step)
        begin
            if (!col_last)
                tile_column_next = tile_column_reg + COL_W'(1);
            else
            begin
                tile_column_next = '0;
                if (!row_last)
                    row_in_tile_next = row_in_tile_reg + ROW_W'(1);
                else
                begin
                    row_in_tile_next = '0;
                    tile_band_next   = band_last ? '0 : tile_band_reg + BAND_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_column_reg <= '0;
            row_in_tile_reg <= '0;
            tile_band_reg   <= '0;
        end
        else
        begin
            tile_column_reg <= tile_column_next;
            row_in_tile_reg <= row_in_tile_next;
            tile_band_reg   <= tile_band_next;
        end
    end

endmodule

[src/raster_to_tile_nibble_packer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_to_tile_nibble_packer_unit
// Packs raster pixel groups into 4bpp tile row words with tile-order address.
// ----------------------------------------------------------------------------
// Usage:
//   pix_*  : one word of eight 4-bit pixels per handshake, raster order.
//   tile_* : one word per input: packed nibbles, address in 8x8 tile order
//            ((band*width + tile)*8 + row), and frame_end on the last word.
//   cfg_*  : register writes (index 0 width_tiles, 1 height_tiles), always
//            ready; write only while the unit is idle.
// An accepted word shows as output valid in the next cycle. Throughput is one
// word per cycle unless stalled; the output register is the only stage.
// A stalled receiver holds the output register; input ready then drops
// until the output word is taken, and reloads in the same cycle it is taken.
// Reset clears the position counters and output valid and loads the default
// size of 30 x 20 tiles.
// ----------------------------------------------------------------------------
module raster_to_tile_nibble_packer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  rtnp_pkg::pix_word_t           pix_word,
    output logic                          tile_valid,
    input  logic                          tile_ready,
    output rtnp_pkg::tile_word_t          tile_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rtnp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtnp_pkg::SIZE_W-1:0]   cfg_data
);
    import rtnp_pkg::*;

    logic [SIZE_W-1:0] width_tiles_reg, height_tiles_reg;
    logic              tile_valid_reg, tile_valid_next;
    tile_word_t        tile_word_reg;
    rtnp_pos_t         pos;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign pix_ready = !tile_valid_reg || tile_ready;
    assign accept    = pix_valid && pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_tiles_reg  <= SIZE_W'(30);
            height_tiles_reg <= SIZE_W'(20);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH_TILES:  width_tiles_reg  <= cfg_data;
                REG_HEIGHT_TILES: height_tiles_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rtnp_addr_gen u_addr_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .width_tiles  (width_tiles_reg),
        .height_tiles (height_tiles_reg),
        .pos          (pos)
    );

    assign tile_valid_next = accept || (tile_valid_reg && !tile_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tile_valid_reg <= 1'b0;
        else
            tile_valid_reg <= tile_valid_next;
    end

    // pix0 sits in the low nibble by struct layout
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tile_word_reg.packed_word  <= pix_word;
            tile_word_reg.word_address <= pos.word_address;
            tile_word_reg.frame_end    <= pos.frame_end;
        end
    end

    assign tile_valid = tile_valid_reg;
    assign tile_word  = tile_word_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |-> (!tile_valid || tile_ready))
        else $error("input accepted over an untaken output word");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> tile_valid)
        else $error("accepted word did not reach the output");

    a_end_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (tile_valid && tile_word.frame_end) |-> (tile_word.word_address[2:0] == 3'b111))
        else $error("frame end outside the last tile row");

endmodule
